>>> sv/sap_pkg.sv
// Shared constants for the sensor advertisement packet sequencer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package sap_pkg;

	localparam int ADV_MAX_BYTES = 31;
	localparam int PAYLOAD_LEN   = 30;

	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 16;
	localparam int CAP_W      = 8;
	localparam int MV_W       = 16;
	localparam int MS_W       = 24;
	localparam int CNT_W      = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd31;
	localparam logic [CAP_W-1:0] CAP_MIN   = 8'(PAYLOAD_LEN);
	localparam bit SIZE_OK = (ADV_MAX_BYTES >= PAYLOAD_LEN);

	// header bytes
	localparam logic [7:0] FLAGS_LEN   = 8'h02;
	localparam logic [7:0] FLAGS_TYPE  = 8'h01;
	localparam logic [7:0] FLAGS_VAL   = 8'h06;
	localparam logic [7:0] SVC_LEN     = 8'(PAYLOAD_LEN - 4);
	localparam logic [7:0] SVC_TYPE    = 8'h16;
	localparam logic [7:0] UUID_LO     = 8'hD2;
	localparam logic [7:0] UUID_HI     = 8'hFC;
	localparam logic [7:0] DEV_INFO    = 8'((2 << 5) | 8'h04);

	// object ids
	localparam logic [7:0] OBJ_PKT_ID  = 8'h00;
	localparam logic [7:0] OBJ_VOLT    = 8'h0C;
	localparam logic [7:0] OBJ_WK      = 8'h0F;
	localparam logic [7:0] OBJ_CONN    = 8'h19;
	localparam logic [7:0] OBJ_RUN     = 8'h27;
	localparam logic [7:0] OBJ_CNT     = 8'h3D;
	localparam logic [7:0] OBJ_DUR     = 8'h42;

	localparam logic [MS_W-1:0] MS_MAX = 24'hFFFFFF;

	localparam logic [0:0] ACT_UPDATE   = 1'b0;
	localparam logic [0:0] ACT_FAREWELL = 1'b1;

endpackage

>>> sv/sensor_advert_packet_sequencer.sv
// Top level of the sensor advertisement packet sequencer.
// Depends on sap_pkg (payload layout, widths, object ids).
`timescale 1ns / 1ps

// Usage
//  s_*   : status requests. tdata carries the sensor fields, tuser the action
//          (0 status update, 1 farewell that resends the last status with
//          awake and running cleared).
//  m_*   : payload bytes, one request per byte, 30 per published packet,
//          tlast on byte 29. tdata = {index, byte}.
//  cfg_* : output_capacity writes; always ready, applied at the handshake.
// Flow: an accepted status lands in the input register and is compared there
//  against the stored last-published values; if it publishes, it waits for the
//  sequencer, and once taken, byte 0 is on m_tdata in the next cycle.
// Throughput: a publishing status occupies the byte sequencer for all 30 bytes
//  (one byte per cycle with m_tready high); a status that publishes nothing
//  retires without waiting on the sequencer. The next status is evaluated while
//  the previous packet is still draining and is held only if it must publish.
// Stall: with m_tready low the current byte holds; once the input register is
//  full and waits on the sequencer, s_tready drops.
// Reset: arst_n clears all state but the input register data: nothing sent,
//  packet id 0, stored values 0, capacity 31. The first published packet carries id 0.
module sensor_advert_packet_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// [24:0] battery_volts_q16, [25] work_flag, [26] awake_flag,
	// [27] running_flag, [43:28] completed_count, [63:44] remaining_seconds,
	// [83:64] selected_seconds, [87:84] zero
	input  logic [sap_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] action
	input  logic                           s_tuser,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] payload_byte, [12:8] byte_index, [15:13] zero
	output logic [sap_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [sap_pkg::CAP_W-1:0]      cfg_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready
);
	import sap_pkg::*;

	// ---------------- input conversion (ahead of the input register) -------
	logic signed [24:0] volts_in;
	logic signed [19:0] rem_in, sel_in;
	logic [33:0]        mv_prod;
	logic [17:0]        mv_round;
	logic [MV_W-1:0]    mv_in;
	logic [28:0]        rem_prod, sel_prod;
	logic [MS_W-1:0]    rem_ms_in, sel_ms_in;

	assign volts_in = s_tdata[24:0];
	assign rem_in   = s_tdata[63:44];
	assign sel_in   = s_tdata[83:64];

	// mV = round(v * 1000 / 65536), half up
	assign mv_prod  = {10'd0, volts_in[23:0]} * 34'd1000 + 34'd32768;
	assign mv_round = mv_prod[33:16];

	always_comb begin
		if (volts_in[24] || volts_in == '0)
			mv_in = '0;
		else if (mv_round >= 18'd65535)
			mv_in = '1;
		else
			mv_in = mv_round[MV_W-1:0];
	end

	assign rem_prod = {10'd0, rem_in[18:0]} * 29'd1000;
	assign sel_prod = {10'd0, sel_in[18:0]} * 29'd1000;

	always_comb begin
		if (rem_in[19] || rem_in == '0)
			rem_ms_in = '0;
		else if (rem_prod > {5'd0, MS_MAX})
			rem_ms_in = MS_MAX;
		else
			rem_ms_in = rem_prod[MS_W-1:0];

		if (sel_in[19] || sel_in == '0)
			sel_ms_in = '0;
		else if (sel_prod > {5'd0, MS_MAX})
			sel_ms_in = MS_MAX;
		else
			sel_ms_in = sel_prod[MS_W-1:0];
	end

	// ---------------- input register ----------------
	logic             vld_s1;
	logic             act_s1;
	logic [MV_W-1:0]  mv_s1;
	logic             wk_s1, aw_s1, rn_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [MS_W-1:0]  rem_s1, sel_s1;
	logic             in_take;

	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			act_s1 <= s_tuser;
			mv_s1  <= mv_in;
			wk_s1  <= s_tdata[25];
			aw_s1  <= s_tdata[26];
			rn_s1  <= s_tdata[27];
			cnt_s1 <= s_tdata[43:28];
			rem_s1 <= rem_ms_in;
			sel_s1 <= sel_ms_in;
		end
	end

	// ---------------- last published values (also the frame source) -------
	logic             sent_q;
	logic [7:0]       id_q;
	logic [MV_W-1:0]  mv_q;
	logic             wk_q, aw_q, rn_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MS_W-1:0]  rem_q, sel_q;
	logic [CAP_W-1:0] cap_q;

	// ---------------- byte sequencer ----------------
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_take, frame_free;

	assign out_take   = m_tvalid && m_tready;
	assign frame_free = !busy_q || (out_take && idx_q == LAST_IDX);

	// ---------------- decision ----------------
	logic             farewell;
	logic [MV_W-1:0]  mv_n;
	logic             wk_n, aw_n, rn_n;
	logic [CNT_W-1:0] cnt_n;
	logic [MS_W-1:0]  rem_n, sel_n;
	logic             unchanged, publish, fire;

	assign farewell = (act_s1 == ACT_FAREWELL);

	always_comb begin
		if (farewell) begin
			mv_n  = mv_q;
			wk_n  = wk_q;
			aw_n  = 1'b0;
			rn_n  = 1'b0;
			cnt_n = cnt_q;
			rem_n = rem_q;
			sel_n = sel_q;
		end else begin
			mv_n  = mv_s1;
			wk_n  = wk_s1;
			aw_n  = aw_s1;
			rn_n  = rn_s1;
			cnt_n = cnt_s1;
			rem_n = rem_s1;
			sel_n = sel_s1;
		end
	end

	assign unchanged = sent_q && mv_n == mv_q && wk_n == wk_q && aw_n == aw_q &&
	                   rn_n == rn_q && cnt_n == cnt_q && rem_n == rem_q &&
	                   sel_n == sel_q;

	// farewell with nothing sent yet, duplicates and small receivers drop out
	assign publish = !(farewell && !sent_q) && !unchanged &&
	                 (cap_q >= CAP_MIN) && SIZE_OK;

	// a drop retires at once; a publish waits for the sequencer
	assign fire     = vld_s1 && (!publish || frame_free);
	assign s_tready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= 1'b0;
			id_q   <= '0;
			mv_q   <= '0;
			wk_q   <= 1'b0;
			aw_q   <= 1'b0;
			rn_q   <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			sel_q  <= '0;
		end else if (fire && publish) begin
			sent_q <= 1'b1;
			id_q   <= sent_q ? id_q + 8'd1 : 8'd0;
			mv_q   <= mv_n;
			wk_q   <= wk_n;
			aw_q   <= aw_n;
			rn_q   <= rn_n;
			cnt_q  <= cnt_n;
			rem_q  <= rem_n;
			sel_q  <= sel_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (fire && publish) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_take) begin
			if (idx_q == LAST_IDX)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// ---------------- byte select ----------------
	logic [7:0] byte_sel;

	always_comb begin
		case (idx_q)
			5'd0:    byte_sel = FLAGS_LEN;
			5'd1:    byte_sel = FLAGS_TYPE;
			5'd2:    byte_sel = FLAGS_VAL;
			5'd3:    byte_sel = SVC_LEN;
			5'd4:    byte_sel = SVC_TYPE;
			5'd5:    byte_sel = UUID_LO;
			5'd6:    byte_sel = UUID_HI;
			5'd7:    byte_sel = DEV_INFO;
			5'd8:    byte_sel = OBJ_PKT_ID;
			5'd9:    byte_sel = id_q;
			5'd10:   byte_sel = OBJ_VOLT;
			5'd11:   byte_sel = mv_q[7:0];
			5'd12:   byte_sel = mv_q[15:8];
			5'd13:   byte_sel = OBJ_WK;
			5'd14:   byte_sel = {7'd0, wk_q};
			5'd15:   byte_sel = OBJ_CONN;
			5'd16:   byte_sel = {7'd0, aw_q};
			5'd17:   byte_sel = OBJ_RUN;
			5'd18:   byte_sel = {7'd0, rn_q};
			5'd19:   byte_sel = OBJ_CNT;
			5'd20:   byte_sel = cnt_q[7:0];
			5'd21:   byte_sel = cnt_q[15:8];
			5'd22:   byte_sel = OBJ_DUR;
			5'd23:   byte_sel = rem_q[7:0];
			5'd24:   byte_sel = rem_q[15:8];
			5'd25:   byte_sel = rem_q[23:16];
			5'd26:   byte_sel = OBJ_DUR;
			5'd27:   byte_sel = sel_q[7:0];
			5'd28:   byte_sel = sel_q[15:8];
			5'd29:   byte_sel = sel_q[23:16];
			default: byte_sel = 8'h00;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = (idx_q == LAST_IDX);
	assign m_tdata  = {3'd0, idx_q, byte_sel};

endmodule

>>> sv/sap_checker.sv
// Port-level checks for the sensor advertisement packet sequencer.
// Depends on sap_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module sap_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic [sap_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready
);
	import sap_pkg::*;

	logic [IDX_W-1:0] idx;
	assign idx = m_tdata[7+IDX_W:8];

	// tlast marks exactly the final byte position
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (idx == LAST_IDX)))
		else $error("tlast does not match byte index");

	// bytes of a packet follow back to back in index order
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && idx == IDX_W'($past(idx) + IDX_W'(1))))
		else $error("packet broken or out of order");

	// every packet opens with the flags length byte
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && idx == '0) |-> (m_tdata[7:0] == FLAGS_LEN))
		else $error("packet does not start with flags structure");

	// stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output changed while stalled");

endmodule

bind sensor_advert_packet_sequencer sap_checker u_sap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

>>> tb/sv/tb_sensor_advert_packet_sequencer.sv
// Testbench for sensor_advert_packet_sequencer: sends status and farewell requests,
// predicts every advertisement byte and checks the byte stream against it.
// Depends on sap_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_sensor_advert_packet_sequencer;

	// advertisement layout, written out independently of the RTL package
	localparam int          ADV_BYTES        = 30;
	localparam logic [7:0]  AD_FLAGS_LEN     = 8'h02;
	localparam logic [7:0]  AD_FLAGS_TYPE    = 8'h01;
	localparam logic [7:0]  AD_FLAGS_VALUE   = 8'h06;
	localparam logic [7:0]  AD_SVC_LEN       = 8'd26;
	localparam logic [7:0]  AD_TYPE_SVC_DATA = 8'h16;
	localparam logic [15:0] SVC_UUID         = 16'hFCD2;
	localparam logic [7:0]  AD_DEV_INFO      = 8'h44;  // version 2, trigger based
	localparam logic [7:0]  ID_PACKET        = 8'h00;
	localparam logic [7:0]  ID_BATTERY_MV    = 8'h0C;
	localparam logic [7:0]  ID_WORK          = 8'h0F;
	localparam logic [7:0]  ID_CONNECTIVITY  = 8'h19;
	localparam logic [7:0]  ID_RUNNING       = 8'h27;
	localparam logic [7:0]  ID_COUNT         = 8'h3D;
	localparam logic [7:0]  ID_DURATION      = 8'h42;
	localparam longint      MS_CEILING       = 64'hFFFFFF;
	localparam logic [7:0]  CAP_AT_RESET     = 8'd31;

	// after the last byte, a non-publishing request may still sit in the
	// input register; keep waiting so that it retires too
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [0:0]         action;
		logic signed [24:0] volts_q16;
		logic               work;
		logic               awake;
		logic               running;
		logic [15:0]        count;
		logic signed [19:0] remaining_s;
		logic signed [19:0] selected_s;
	} status_t;

	typedef struct {
		logic [7:0] data;
		logic [4:0] index;
		logic       last;
	} adv_byte_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic [sap_pkg::IN_DATA_W-1:0]     s_tdata   = '0;
	logic                              s_tuser   = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [sap_pkg::OUT_DATA_W-1:0]    m_tdata;
	logic                              m_tlast;
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [sap_pkg::CAP_W-1:0]         cfg_data  = '0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;

	// both sides run without idle cycles while this is set
	logic steady  = 1'b0;
	// receiver held off completely while this is set
	logic rx_hold = 1'b0;

	int mismatches = 0;

	// predictor copy of the block state
	logic [7:0]  cap_model   = CAP_AT_RESET;
	logic        published   = 1'b0;
	logic [7:0]  pub_id      = '0;
	logic [15:0] pub_mv      = '0;
	logic        pub_work    = 1'b0;
	logic        pub_awake   = 1'b0;
	logic        pub_running = 1'b0;
	logic [15:0] pub_count   = '0;
	logic [23:0] pub_rem_ms  = '0;
	logic [23:0] pub_sel_ms  = '0;

	// bytes predicted but not yet seen on the master side, oldest first
	adv_byte_t adv_bytes_due[$];

	always #1 clk = ~clk;

	sensor_advert_packet_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	// ---------------------------------------------------------------- predictor

	// q16 volts -> mV, round half up, zero when not positive, saturate at 16 bits
	function automatic logic [15:0] volts_to_mv(logic signed [24:0] v);
		longint scaled;
		if (v <= 0)
			return 16'd0;
		scaled = (longint'(v) * 1000 + 32768) >>> 16;
		return (scaled >= 65535) ? 16'hFFFF : scaled[15:0];
	endfunction

	// seconds -> ms, zero when not positive, clamped to 24 bits
	function automatic logic [23:0] secs_to_ms(logic signed [19:0] s);
		longint ms;
		if (s <= 0)
			return 24'd0;
		ms = longint'(s) * 1000;
		return (ms > MS_CEILING) ? MS_CEILING[23:0] : ms[23:0];
	endfunction

	// Works out what one accepted request publishes and queues its bytes.
	task automatic predict_advert(input status_t st);
		logic [15:0] mv;
		logic        wk, aw, rn;
		logic [15:0] cnt;
		logic [23:0] rem, sel;
		logic [7:0]  id;
		logic [7:0]  pkt [ADV_BYTES];
		if (st.action == sap_pkg::ACT_FAREWELL) begin
			// farewell replays the last publish, awake and running dropped
			if (!published)
				return;
			mv  = pub_mv;
			wk  = pub_work;
			aw  = 1'b0;
			rn  = 1'b0;
			cnt = pub_count;
			rem = pub_rem_ms;
			sel = pub_sel_ms;
		end else begin
			mv  = volts_to_mv(st.volts_q16);
			wk  = st.work;
			aw  = st.awake;
			rn  = st.running;
			cnt = st.count;
			rem = secs_to_ms(st.remaining_s);
			sel = secs_to_ms(st.selected_s);
		end
		// unchanged payload: suppressed
		if (published && mv == pub_mv && wk == pub_work && aw == pub_awake &&
				rn == pub_running && cnt == pub_count && rem == pub_rem_ms &&
				sel == pub_sel_ms)
			return;
		// receiver too small: nothing goes out and the state stays
		if (cap_model < ADV_BYTES)
			return;
		id = published ? pub_id + 8'd1 : 8'd0;
		pkt = '{AD_FLAGS_LEN, AD_FLAGS_TYPE, AD_FLAGS_VALUE,
			AD_SVC_LEN, AD_TYPE_SVC_DATA, SVC_UUID[7:0], SVC_UUID[15:8], AD_DEV_INFO,
			ID_PACKET, id,
			ID_BATTERY_MV, mv[7:0], mv[15:8],
			ID_WORK, {7'd0, wk},
			ID_CONNECTIVITY, {7'd0, aw},
			ID_RUNNING, {7'd0, rn},
			ID_COUNT, cnt[7:0], cnt[15:8],
			ID_DURATION, rem[7:0], rem[15:8], rem[23:16],
			ID_DURATION, sel[7:0], sel[15:8], sel[23:16]};
		published   = 1'b1;
		pub_id      = id;
		pub_mv      = mv;
		pub_work    = wk;
		pub_awake   = aw;
		pub_running = rn;
		pub_count   = cnt;
		pub_rem_ms  = rem;
		pub_sel_ms  = sel;
		for (int i = 0; i < ADV_BYTES; i++)
			adv_bytes_due.push_back('{pkt[i], 5'(i), i == ADV_BYTES - 1});
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	function automatic status_t make_status(logic [0:0] action, logic signed [24:0] volts,
			logic work, logic awake, logic running, logic [15:0] count,
			logic signed [19:0] rem_s, logic signed [19:0] sel_s);
		status_t st;
		st = '{action, volts, work, awake, running, count, rem_s, sel_s};
		return st;
	endfunction

	function automatic logic signed [19:0] random_secs();
		case ($urandom_range(3))
			0: return 20'($urandom);
			1: return 20'($urandom_range(3600));
			2: return 20'($urandom_range(16800, 16750));  // around the 24-bit clamp
			default: return 20'($urandom_range(10) - 5);
		endcase
	endfunction

	function automatic status_t random_status();
		status_t st;
		st.action = sap_pkg::ACT_UPDATE;
		case ($urandom_range(3))
			0: st.volts_q16 = 25'($urandom);
			1: st.volts_q16 = 25'($urandom_range(294912, 196608));    // 3.0 .. 4.5 V
			2: st.volts_q16 = 25'($urandom_range(80) - 40);           // around zero
			default: st.volts_q16 = 25'($urandom_range(4300000, 4290000));  // near saturation
		endcase
		st.work        = 1'($urandom);
		st.awake       = 1'($urandom);
		st.running     = 1'($urandom);
		st.count       = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(20));
		st.remaining_s = random_secs();
		st.selected_s  = random_secs();
		return st;
	endfunction

	// same status with one field moved a little
	function automatic status_t nudge_status(status_t st);
		case ($urandom_range(6))
			0: st.volts_q16 = st.volts_q16 + 25'sd1;  // often lands on the same mV
			1: st.work = ~st.work;
			2: st.awake = ~st.awake;
			3: st.running = ~st.running;
			4: st.count = st.count + 16'd1;
			5: st.remaining_s = st.remaining_s + 20'sd1;
			default: st.selected_s = st.selected_s + 20'sd1;
		endcase
		return st;
	endfunction

	// One status request; returns in the step of its handshake.
	task automatic send_status(input status_t st);
		if (!steady && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= st.action;
		s_tdata  <= {4'd0, st.selected_s, st.remaining_s, st.count,
			st.running, st.awake, st.work, st.volts_q16};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_advert(st);
	endtask

	task automatic write_capacity(input logic [7:0] cap);
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cap_model = cap;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and let every predicted byte come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (adv_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic hold_receiver(input int unsigned cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// Field extremes, rounding and clamping edges, farewell and suppression.
	task automatic test_directed();
		status_t st;
		// farewell with nothing published yet: silent
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sd1000, 1'b1, 1'b1, 1'b1,
			16'd5, 20'sd5, 20'sd5));
		// all-zero status still publishes the very first time, id 0
		st = make_status(sap_pkg::ACT_UPDATE, 25'sd0, 1'b0, 1'b0, 1'b0, 16'd0, 20'sd0, 20'sd0);
		send_status(st);
		send_status(st);  // identical: suppressed
		// farewell equal to what is stored: suppressed
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sd0, 1'b0, 1'b0, 1'b0,
			16'd0, 20'sd0, 20'sd0));
		// top of every field: mV saturates, both durations clamp
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sh0FFFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF,
			20'sh7FFFF, 20'sh7FFFF));
		// farewell drops awake and running, then repeats as a no-op
		send_status(make_status(sap_pkg::ACT_FAREWELL, -25'sd7, 1'b0, 1'b1, 1'b1,
			16'd9, -20'sd1, 20'sd3));
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sd12345, 1'b1, 1'b0, 1'b1,
			16'd1, 20'sd1, 20'sd1));
		// bottom of the signed fields: all give zero
		send_status(make_status(sap_pkg::ACT_UPDATE, -25'sh1000000, 1'b1, 1'b0, 1'b1, 16'd0,
			-20'sh80000, -20'sd1));
		// rounding: 32 rounds down, 33 rounds up, 1 is zero
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd1, 1'b0, 1'b1, 1'b0,
			16'd1, 20'sd0, 20'sd0));
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd32, 1'b0, 1'b1, 1'b0,
			16'd2, 20'sd0, 20'sd0));
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd33, 1'b0, 1'b1, 1'b0,
			16'd2, 20'sd0, 20'sd0));
		// mV just below and at the saturation point
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd4294000, 1'b1, 1'b1, 1'b0,
			16'd3, 20'sd1, 20'sd0));
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd4294917, 1'b1, 1'b1, 1'b0,
			16'd3, 20'sd1, 20'sd0));
		// durations on either side of the 24-bit clamp
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd262144, 1'b0, 1'b0, 1'b1, 16'h8000,
			20'sd16777, 20'sd16778));
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sd262144, 1'b0, 1'b0, 1'b1, 16'h8000,
			20'sd1, 20'sd0));
		// status fields of a farewell are ignored
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sh0FFFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF,
			20'sh7FFFF, 20'sh7FFFF));
		send_status(make_status(sap_pkg::ACT_UPDATE, 25'sh0AAAAAA, 1'b1, 1'b1, 1'b0, 16'h5555,
			20'sh2AAAA, 20'sh55555));
		drain_results();
	endtask

	// Capacity below 30 blocks publishing and leaves the state alone.
	task automatic test_capacity();
		status_t st;
		st = make_status(sap_pkg::ACT_UPDATE, 25'sd220000, 1'b1, 1'b1, 1'b1, 16'd77,
			20'sd600, 20'sd1500);
		write_capacity(8'd29);
		send_status(st);
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sd0, 1'b0, 1'b0, 1'b0,
			16'd0, 20'sd0, 20'sd0));
		drain_results();
		write_capacity(8'd0);
		send_status(st);
		drain_results();
		// same request now goes out, id continuing from the last real publish
		write_capacity(8'd255);
		send_status(st);
		send_status(make_status(sap_pkg::ACT_FAREWELL, 25'sd0, 1'b0, 1'b0, 1'b0,
			16'd0, 20'sd0, 20'sd0));
		drain_results();
		write_capacity(8'd30);
		send_status(nudge_status(st));
		drain_results();
		write_capacity(CAP_AT_RESET);
	endtask

	// Receiver stalls for a long stretch; the block fills and holds s_tready low.
	task automatic test_output_backpressure();
		status_t st;
		drain_results();
		fork
			hold_receiver(400);
		join_none
		for (int i = 0; i < 10; i++) begin
			st = random_status();
			st.count = 16'(1000 + i);
			send_status(st);
		end
		drain_results();
	endtask

	// Mostly plausible traffic: fresh readings, repeats, small changes, farewells.
	task automatic test_random_traffic(input int n_items);
		status_t st, prev;
		int      pick;
		prev = random_status();
		for (int i = 0; i < n_items; i++) begin
			if (i != 0 && i % 60 == 0) begin
				drain_results();
				case ($urandom_range(7))
					0: write_capacity(8'($urandom_range(29)));
					1: write_capacity(8'd30);
					2: write_capacity(8'd255);
					default: write_capacity(8'($urandom_range(255, 30)));
				endcase
			end
			if (i == n_items / 3)
				steady <= 1'b1;
			else if (i == n_items / 3 + 60)
				steady <= 1'b0;
			pick = $urandom_range(99);
			if (pick < 12) begin
				st = random_status();
				st.action = sap_pkg::ACT_FAREWELL;
			end else if (pick < 22) begin
				st = prev;
			end else if (pick < 40) begin
				st = nudge_status(prev);
			end else begin
				st = random_status();
			end
			if (st.action == sap_pkg::ACT_UPDATE)
				prev = st;
			send_status(st);
		end
		drain_results();
	endtask

	// ---------------------------------------------------------------- receiver and checker

	// Compares each accepted byte with the oldest prediction and drives m_tready.
	always @(posedge clk) begin : byte_check
		adv_byte_t due;
		if (m_tvalid && m_tready) begin
			if (adv_bytes_due.size() == 0) begin
				$error("unexpected payload byte %h at index %0d", m_tdata[7:0], m_tdata[12:8]);
				mismatches++;
			end else begin
				due = adv_bytes_due.pop_front();
				if (m_tdata[7:0] !== due.data) begin
					$error("payload_byte: expected %h, got %h", due.data, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[12:8] !== due.index) begin
					$error("byte_index: expected %0d, got %0d", due.index, m_tdata[12:8]);
					mismatches++;
				end
				if (m_tlast !== due.last) begin
					$error("last_byte: expected %b, got %b", due.last, m_tlast);
					mismatches++;
				end
			end
		end
		m_tready <= arst_n && !rx_hold && (steady || $urandom_range(99) >= 7);
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_output_backpressure();
		test_random_traffic(330);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_sensor_advert_packet_sequencer: done, clean");
		else
			$display("tb_sensor_advert_packet_sequencer: done, errors");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("tb_sensor_advert_packet_sequencer: done, errors");
		$finish;
	end

endmodule

>>> files.f
sv/sap_pkg.sv
sv/sensor_advert_packet_sequencer.sv
sv/sap_checker.sv
tb/sv/tb_sensor_advert_packet_sequencer.sv
